// ===== design/pnpf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnpf_pkg
// Shared types and constants for the per-node point queue.
// ----------------------------------------------------------------------------
package pnpf_pkg;

    localparam int ST_W  = 16;   // status word width
    localparam int PT_W  = 32;   // point field width on the ports
    localparam int IDX_W = 6;    // queue index / fill count width
    localparam int NODE_W = 7;   // node field width

    // Request kinds
    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_READ  = 2'd1,
        KIND_RESET = 2'd2,
        KIND_QUERY = 2'd3
    } kind_t;

    // Status word masks
    localparam logic [ST_W-1:0] ST_CLEAR_B15 = 16'h7FFF;
    localparam logic [ST_W-1:0] ST_CLOSE_BAD = 16'h0400;
    localparam logic [ST_W-1:0] ST_OVERRUN   = 16'h2000;
    localparam logic [ST_W-1:0] ST_EMPTY     = 16'h4000;
    localparam logic [ST_W-1:0] ST_KEEP_MID  = 16'h7FC0;

    // Per-node queue bookkeeping
    typedef struct packed {
        logic [IDX_W-1:0] wr_idx;
        logic [IDX_W-1:0] rd_idx;
        logic [IDX_W-1:0] cnt;
        logic [PT_W-1:0]  last;
    } meta_t;

endpackage

// ===== design/pnpf_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnpf_req_if
// Request channel: valid/ready with one queue operation.
// ----------------------------------------------------------------------------
interface pnpf_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [6:0]         node;
    logic signed [31:0] point;
    logic signed [31:0] seg_time;
    logic signed [31:0] seg_period;
    logic [15:0]        status_in;

    modport source (
        output valid, kind, node, point, seg_time, seg_period, status_in,
        input  ready
    );
    modport sink (
        input  valid, kind, node, point, seg_time, seg_period, status_in,
        output ready
    );
endinterface

// ===== design/pnpf_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnpf_rsp_if
// Response channel: valid/ready with the updated status and dequeued point.
// ----------------------------------------------------------------------------
interface pnpf_rsp_if;
    logic               valid;
    logic               ready;
    logic [15:0]        status_out;
    logic signed [31:0] point_out;
    logic               point_valid;

    modport source (
        output valid, status_out, point_out, point_valid,
        input  ready
    );
    modport sink (
        input  valid, status_out, point_out, point_valid,
        output ready
    );
endinterface

// ===== design/pnpf_meta_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnpf_meta_mem
// Per-node queue state memory, registered read, with a valid
// bit per node so that unwritten nodes read as empty.
// ----------------------------------------------------------------------------
module pnpf_meta_mem
    import pnpf_pkg::*;
#(
    parameter int ENTRIES = 128,
    parameter int AW      = 7
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output meta_t         rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  meta_t         wr_data
);

    meta_t              mem [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;
    meta_t              rd_q;
    logic               rd_valid_q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_q       <= mem[rd_addr];
            rd_valid_q <= valid_reg[rd_addr];
        end
    end

    // never-written node reads as reset state
    assign rd_data = rd_valid_q ? rd_q : '0;

endmodule

// ===== design/pnpf_point_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnpf_point_mem
// Point storage for all queues, one write and one registered read port.
// ----------------------------------------------------------------------------
module pnpf_point_mem #(
    parameter int ENTRIES = 5760,
    parameter int AW      = 13,
    parameter int DW      = 32
)
(
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data
);

    logic [DW-1:0] mem [ENTRIES];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== design/per_node_point_fifo_with_status_unit.sv =====
`timescale 1ns / 1ps
// Sequencing: an accepted request passes S_META and S_EXEC; its response enters
//   the output register from S_EXEC, held back while the previous one waits.
//   A new request is taken only in S_IDLE; each in-range request makes two
//   dependent reads (node state, then the stored point) before any write-back.
// Reset: asynchronous, active low; clears control and the per-node valid
//   bits, so every queue starts empty with last point zero. No clearing pass.
// ----------------------------------------------------------------------------
// per_node_point_fifo_with_status_unit
// Per-node circular point queues with interpolator status word update.
// ----------------------------------------------------------------------------
module per_node_point_fifo_with_status_unit
    import pnpf_pkg::*;
#(
    parameter int NODES       = 128,
    parameter int DEPTH       = 45,
    parameter int POINT_WIDTH = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    pnpf_req_if.sink   req,
    pnpf_rsp_if.source rsp
);

    // Stored point width never exceeds the port width.
    localparam int PW       = (POINT_WIDTH < PT_W) ? POINT_WIDTH : PT_W;
    // Only 128 node numbers fit in the node field.
    localparam int NODE_CNT = (NODES < (1 << NODE_W)) ? NODES : (1 << NODE_W);
    localparam int NODE_AW  = (NODE_CNT > 1) ? $clog2(NODE_CNT) : 1;
    localparam int PT_ENT   = NODE_CNT * DEPTH;
    localparam int PA_W     = $clog2(PT_ENT);
    localparam logic [IDX_W-1:0] DEPTH_C = IDX_W'(DEPTH);
    localparam logic [IDX_W-1:0] LAST_C  = IDX_W'(DEPTH - 1);

    // Sequencer: accept -> node state read -> point read -> update/write-back
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_META = 3'b010,
        S_EXEC = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // Captured request
    kind_t              kind_reg;
    logic [NODE_W-1:0]  node_reg;
    logic [PT_W-1:0]    point_reg;     // already cut to PW bits
    logic               close_reg;     // both times zero
    logic [ST_W-1:0]    status_reg;
    logic               in_range_reg;
    logic [PA_W-1:0]    base_reg;      // node * DEPTH

    // Output register
    logic               out_valid_reg, out_valid_next;
    logic [ST_W-1:0]    out_status_reg;
    logic [PT_W-1:0]    out_point_reg;
    logic               out_pvalid_reg;

    // Memory hookup
    meta_t              meta_rd;
    meta_t              meta_new;
    logic               meta_rd_en, meta_wr_en;
    logic [NODE_AW-1:0] node_idx;
    logic [PA_W-1:0]    base_now;
    logic               pt_rd_en, pt_wr_en;
    logic [PA_W-1:0]    pt_rd_addr, pt_wr_addr;
    logic [PW-1:0]      pt_rd_data;

    // Update results
    logic [ST_W-1:0]    st_new;
    logic [ST_W-1:0]    st_inc;
    logic [PT_W-1:0]    pout_new;
    logic               pvalid_new;
    logic               pt_store;

    logic               accept;
    logic               out_free;
    logic               fire;

    assign accept   = req.valid && req.ready;
    assign out_free = !out_valid_reg || rsp.ready;
    assign fire     = (state_reg == S_EXEC) && out_free;
    assign req.ready = (state_reg == S_IDLE);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_META;
                end
            end
            S_META:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            in_range_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                in_range_reg <= ({2'b00, req.node} < 9'(NODES));
            end
        end
    end

    // Request capture (payload, no reset)
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg   <= kind_t'(req.kind);
            node_reg   <= req.node;
            point_reg  <= PT_W'(req.point[PW-1:0]);
            close_reg  <= (req.seg_time == '0) && (req.seg_period == '0);
            status_reg <= req.status_in;
        end
        if (state_reg == S_META)
        begin
            base_reg <= base_now;
        end
    end

    // ------------------------------------------------------------------
    // Node state memory: read at accept, written back when the result fires
    // ------------------------------------------------------------------
    assign node_idx   = node_reg[NODE_AW-1:0];
    assign meta_rd_en = accept && ({2'b00, req.node} < 9'(NODES));
    assign meta_wr_en = fire && in_range_reg && (kind_reg != KIND_QUERY);

    pnpf_meta_mem #(
        .ENTRIES (NODE_CNT),
        .AW      (NODE_AW)
    ) u_meta_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (meta_rd_en),
        .rd_addr (req.node[NODE_AW-1:0]),
        .rd_data (meta_rd),
        .wr_en   (meta_wr_en),
        .wr_addr (node_idx),
        .wr_data (meta_new)
    );

    // ------------------------------------------------------------------
    // Point store: node's slice starts at node * DEPTH
    // ------------------------------------------------------------------
    assign base_now   = PA_W'(node_idx * DEPTH);
    assign pt_rd_en   = (state_reg == S_META) && in_range_reg;
    assign pt_rd_addr = base_now + PA_W'(meta_rd.rd_idx);
    assign pt_wr_en   = fire && pt_store;
    assign pt_wr_addr = base_reg + PA_W'(meta_rd.wr_idx);

    pnpf_point_mem #(
        .ENTRIES (PT_ENT),
        .AW      (PA_W),
        .DW      (PW)
    ) u_point_mem (
        .clk     (clk),
        .rd_en   (pt_rd_en),
        .rd_addr (pt_rd_addr),
        .rd_data (pt_rd_data),
        .wr_en   (pt_wr_en),
        .wr_addr (pt_wr_addr),
        .wr_data (point_reg[PW-1:0])
    );

    // ------------------------------------------------------------------
    // Update: status word and queue bookkeeping
    // ------------------------------------------------------------------
    assign st_inc = status_reg + 16'd1;

    always_comb
    begin
        st_new     = status_reg;
        pout_new   = '0;
        pvalid_new = 1'b0;
        pt_store   = 1'b0;
        meta_new   = meta_rd;
        if (in_range_reg)
        begin
            unique case (kind_reg)
                KIND_WRITE:
                begin
                    if (close_reg)
                    begin
                        // close table: check last point matches
                        if (point_reg == meta_rd.last)
                        begin
                            st_new = status_reg & ST_CLEAR_B15;
                        end
                        else
                        begin
                            st_new = status_reg | ST_CLOSE_BAD;
                        end
                    end
                    else if (meta_rd.cnt >= DEPTH_C)
                    begin
                        st_new = status_reg | ST_OVERRUN;
                    end
                    else
                    begin
                        pt_store        = 1'b1;
                        meta_new.last   = point_reg;
                        meta_new.wr_idx = (meta_rd.wr_idx >= LAST_C) ? '0
                                        : meta_rd.wr_idx + 1'b1;
                        meta_new.cnt    = meta_rd.cnt + 1'b1;
                        st_new          = status_reg - 16'd1;
                    end
                end
                KIND_READ:
                begin
                    if (meta_rd.cnt == '0)
                    begin
                        st_new = status_reg | ST_EMPTY;
                    end
                    else
                    begin
                        pout_new        = PT_W'(pt_rd_data);
                        pvalid_new      = 1'b1;
                        meta_new.rd_idx = (meta_rd.rd_idx >= LAST_C) ? '0
                                        : meta_rd.rd_idx + 1'b1;
                        meta_new.cnt    = meta_rd.cnt - 1'b1;
                        st_new          = (st_inc[IDX_W-1:0] > DEPTH_C)
                                        ? (st_inc | ST_OVERRUN) : st_inc;
                    end
                end
                KIND_RESET:
                begin
                    meta_new.wr_idx = '0;
                    meta_new.rd_idx = '0;
                    meta_new.cnt    = '0;
                    st_new          = (status_reg & ST_KEEP_MID) + ST_W'(DEPTH);
                end
                KIND_QUERY:
                begin
                    st_new = ST_W'(DEPTH) - ST_W'(meta_rd.cnt);
                end
                default:
                begin
                    st_new = status_reg;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_comb
    begin
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_status_reg <= st_new;
            out_point_reg  <= pout_new;
            out_pvalid_reg <= pvalid_new;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status_out  = out_status_reg;
    assign rsp.point_out   = out_point_reg;
    assign rsp.point_valid = out_pvalid_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_meta_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        meta_wr_en |-> in_range_reg)
        else $error("node state written for out-of-range node");

    a_pt_wr_kind: assert property (@(posedge clk) disable iff (!rst_n)
        pt_wr_en |-> (kind_reg == KIND_WRITE) && !close_reg && in_range_reg)
        else $error("point store written by non-enqueue request");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        meta_wr_en |-> (meta_new.cnt <= DEPTH_C))
        else $error("fill count exceeds queue depth");

    a_accept_seq: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_META))
        else $error("accepted request did not start node state read");

    a_exec_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC) && !out_free |=> (state_reg == S_EXEC) && !fire
            || (state_reg == S_EXEC))
        else $error("update left while output register busy");

    a_pvalid_read: assert property (@(posedge clk) disable iff (!rst_n)
        fire && pvalid_new |-> (kind_reg == KIND_READ) && (meta_rd.cnt != '0))
        else $error("point returned without a dequeue");

endmodule
